FILE: design/rpoc_pkg.sv
package rpoc_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned CharW  = 8;

  typedef enum logic [1:0] {
    CmdText    = 2'd0,
    CmdRange   = 2'd1,
    CmdPattern = 2'd2,
    CmdNone    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StBound,
    StRead,
    StCompare
  } state_e;

endpackage

FILE: design/range_pattern_occurrence_count_unit.sv
// channel   ports                                             handshake
// request   cmd_i char_value_i range_start_i range_end_i last_i  start_i & !busy_o
// result    match_count_o                                     done_o, one cycle
//
// text bytes, range requests and pattern bytes other than the last stay in idle.
// a flagged pattern byte runs setup and bound checks, then, if they pass, a read
// state and a compare state per byte compared (one text/pattern memory read, one
// compare); a position's scan stops at its first mismatch. done_o is registered.
// reset clears lengths, range and control; the byte stores are not cleared.
// the receiver cannot stall: match_count_o is valid only while done_o is high.
module range_pattern_occurrence_count_unit #(
  parameter int unsigned TEXT_DEPTH    = 4096,
  parameter int unsigned PATTERN_DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  cmd_i,
  input  logic [rpoc_pkg::CharW-1:0]  char_value_i,
  input  logic [rpoc_pkg::PosW-1:0]   range_start_i,
  input  logic [rpoc_pkg::PosW-1:0]   range_end_i,
  input  logic                        last_i,
  output logic                        done_o,
  output logic [rpoc_pkg::CountW-1:0] match_count_o
);
  import rpoc_pkg::*;

  localparam int unsigned TW  = $clog2(TEXT_DEPTH);
  localparam int unsigned PW  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int unsigned TLW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned PLW = $clog2(PATTERN_DEPTH + 2);
  localparam int unsigned LW  = (TLW > PLW) ? TLW : PLW;
  localparam int unsigned CW  = ((LW > CountW) ? LW : CountW) + 1;

  logic [CharW-1:0] text_mem [TEXT_DEPTH];
  logic [CharW-1:0] pat_mem  [PATTERN_DEPTH];

  state_e state_q, state_d;

  logic [TLW-1:0]    text_len_q, text_len_d;
  logic              text_closed_q, text_closed_d;
  logic [PLW-1:0]    pat_len_q, pat_len_d;
  logic [PosW-1:0]   qry_start_q, qry_start_d;
  logic [PosW-1:0]   qry_end_q, qry_end_d;
  logic              ok_q, ok_d;
  logic [CW-1:0]     lim_a_q, lim_a_d;
  logic [CW-1:0]     lim_b_q, lim_b_d;
  logic [TW-1:0]     p_q, p_d;
  logic [TW-1:0]     last_p_q, last_p_d;
  logic [PW-1:0]     j_q, j_d;
  logic [PW-1:0]     m_last_q, m_last_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;

  logic [CharW-1:0]  text_rd_q, pat_rd_q;

  logic              accept;
  logic              text_we, pat_we, rd_en;
  logic [TW-1:0]     text_waddr, text_raddr;
  logic [PW-1:0]     pat_waddr;
  logic [TLW-1:0]    text_base;
  logic [CW-1:0]     s_w, e_w, m_w, tl_w, span_w, lp_w;
  logic              pos_last, byte_last, byte_eq;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign match_count_o = cnt_q;

  assign text_base  = text_closed_q ? '0 : text_len_q;
  assign text_waddr = text_base[TW-1:0];
  assign pat_waddr  = pat_len_q[PW-1:0];
  assign text_raddr = TW'(CW'(p_q) + CW'(j_q));

  assign s_w    = CW'(qry_start_q);
  assign e_w    = CW'(qry_end_q);
  assign m_w    = CW'(pat_len_q);
  assign tl_w   = CW'(text_len_q);
  assign span_w = e_w - s_w + CW'(1);
  assign lp_w   = (lim_a_q < lim_b_q) ? lim_a_q : lim_b_q;

  assign byte_eq   = (text_rd_q == pat_rd_q);
  assign byte_last = (j_q == m_last_q);
  assign pos_last  = (p_q == last_p_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept && cmd_i == CmdPattern && last_i) state_d = StSetup;
      end
      StSetup: state_d = StBound;
      StBound: begin
        if (ok_q && s_w <= lp_w) state_d = StRead;
        else state_d = StIdle;
      end
      StRead: state_d = StCompare;
      StCompare: begin
        if ((!byte_eq || byte_last) && pos_last) state_d = StIdle;
        else state_d = StRead;
      end
      default: state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    text_len_d    = text_len_q;
    text_closed_d = text_closed_q;
    pat_len_d     = pat_len_q;
    qry_start_d   = qry_start_q;
    qry_end_d     = qry_end_q;
    ok_d          = ok_q;
    lim_a_d       = lim_a_q;
    lim_b_d       = lim_b_q;
    p_d           = p_q;
    last_p_d      = last_p_q;
    j_d           = j_q;
    m_last_d      = m_last_q;
    cnt_d         = cnt_q;
    done_d        = 1'b0;
    text_we       = 1'b0;
    pat_we        = 1'b0;
    rd_en         = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (cmd_i)
            CmdText: begin
              text_closed_d = last_i;
              if (CW'(text_base) < CW'(TEXT_DEPTH)) begin
                text_we    = 1'b1;
                text_len_d = text_base + TLW'(1);
              end else begin
                text_len_d = text_base;
              end
            end
            CmdRange: begin
              qry_start_d = range_start_i;
              qry_end_d   = range_end_i;
              pat_len_d   = '0;
            end
            CmdPattern: begin
              if (CW'(pat_len_q) < CW'(PATTERN_DEPTH)) begin
                pat_we    = 1'b1;
                pat_len_d = pat_len_q + PLW'(1);
              end else begin
                pat_len_d = PLW'(PATTERN_DEPTH + 1);
              end
            end
            default: ;
          endcase
        end
      end
      StSetup: begin
        ok_d = (m_w != '0) && (m_w <= CW'(PATTERN_DEPTH)) && (e_w >= s_w) &&
               (span_w >= m_w) && (m_w <= tl_w);
        lim_a_d  = e_w + CW'(1) - m_w;
        lim_b_d  = tl_w - m_w;
        m_last_d = PW'(m_w - CW'(1));
        cnt_d    = '0;
      end
      StBound: begin
        p_d       = TW'(s_w);
        last_p_d  = TW'(lp_w);
        j_d       = '0;
        pat_len_d = '0;
        if (!(ok_q && s_w <= lp_w)) done_d = 1'b1;
      end
      StRead: rd_en = 1'b1;
      StCompare: begin
        if (byte_eq && !byte_last) begin
          j_d = j_q + PW'(1);
        end else begin
          if (byte_eq) cnt_d = cnt_q + CountW'(1);
          j_d = '0;
          if (pos_last) done_d = 1'b1;
          else p_d = p_q + TW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      text_len_q    <= '0;
      text_closed_q <= 1'b0;
      pat_len_q     <= '0;
      qry_start_q   <= '0;
      qry_end_q     <= '0;
      ok_q          <= 1'b0;
      p_q           <= '0;
      last_p_q      <= '0;
      j_q           <= '0;
      cnt_q         <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      text_len_q    <= text_len_d;
      text_closed_q <= text_closed_d;
      pat_len_q     <= pat_len_d;
      qry_start_q   <= qry_start_d;
      qry_end_q     <= qry_end_d;
      ok_q          <= ok_d;
      p_q           <= p_d;
      last_p_q      <= last_p_d;
      j_q           <= j_d;
      cnt_q         <= cnt_d;
      done_q        <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_a_q  <= lim_a_d;
    lim_b_q  <= lim_b_d;
    m_last_q <= m_last_d;
  end

  // text store
  always_ff @(posedge clk_i) begin
    if (text_we) text_mem[text_waddr] <= char_value_i;
    if (rd_en) text_rd_q <= text_mem[text_raddr];
  end

  // pattern store
  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[pat_waddr] <= char_value_i;
    if (rd_en) pat_rd_q <= pat_mem[j_q];
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCompare) |-> $past(state_q) == StRead)
    else $error("compare without a preceding memory read");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> p_q <= last_p_q)
    else $error("scan position beyond last start position");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> match_count_o <= CountW'(4096))
    else $error("match count exceeds range size");
`endif

endmodule
